FILE: hw/rtl/dq_pkg.sv
package dq_pkg;

  // Ring capacity in words; also the number of cells in the chain.
  localparam int DEPTH  = 1024;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;

  // Operation codes of the input transaction.
  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_SIZE,
    OP_EMPTY,
    OP_FRONT,
    OP_BACK
  } dq_op_t;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [WORD_W-1:0] push_value;
  } dq_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    logic                     was_empty;
  } dq_out_t;

  // One storage slot: a word plus its occupied flag.
  typedef struct packed {
    logic              vld;
    logic [WORD_W-1:0] data;
  } dq_slot_t;

  // Chain-wide move: hold, move every word one cell toward the back (SHR),
  // or one cell toward the front (SHL).
  typedef enum logic [1:0] {
    DQ_HOLD,
    DQ_SHR,
    DQ_SHL
  } dq_shift_t;

  typedef struct packed {
    dq_shift_t cmd;
    dq_slot_t  left_in;   // enters cell 0 on SHR
    dq_slot_t  right_in;  // enters the last cell on SHL
  } dq_ctl_t;

endpackage

FILE: hw/rtl/dq_cell.sv
module dq_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  dq_pkg::dq_shift_t cmd_i,
  input  dq_pkg::dq_slot_t  left_i,
  input  dq_pkg::dq_slot_t  right_i,
  output dq_pkg::dq_slot_t  slot_o
);
  import dq_pkg::*;

  logic              vld_r;
  logic              vld_nxt;
  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;

  always_comb begin
    vld_nxt  = vld_r;
    data_nxt = data_r;
    case (cmd_i)
      DQ_SHR: begin
        vld_nxt  = left_i.vld;
        data_nxt = left_i.data;
      end
      DQ_SHL: begin
        vld_nxt  = right_i.vld;
        data_nxt = right_i.data;
      end
      default: begin
        vld_nxt  = vld_r;
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign slot_o.vld  = vld_r;
  assign slot_o.data = data_r;

endmodule

FILE: hw/rtl/dq_chain.sv
module dq_chain (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dq_pkg::dq_ctl_t            ctl_i,
  output dq_pkg::dq_slot_t           front_o,
  output dq_pkg::dq_slot_t           back_o,
  output logic [dq_pkg::DEPTH-1:0]   vld_o
);
  import dq_pkg::*;

  dq_slot_t slot [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dq_slot_t left_s;
    dq_slot_t right_s;

    if (i == 0) begin : g_left_edge
      assign left_s = ctl_i.left_in;
    end else begin : g_left_nbr
      assign left_s = slot[i-1];
    end

    if (i == DEPTH - 1) begin : g_right_edge
      assign right_s = ctl_i.right_in;
    end else begin : g_right_nbr
      assign right_s = slot[i+1];
    end

    dq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd_i   (ctl_i.cmd),
      .left_i  (left_s),
      .right_i (right_s),
      .slot_o  (slot[i])
    );

    assign vld_o[i] = slot[i].vld;
  end

  assign front_o = slot[0];
  assign back_o  = slot[DEPTH-1];

endmodule

FILE: hw/rtl/double_ended_queue.sv
// Latency: a transaction whose words already sit against the end it uses executes
// at its accepting edge; any result strobes out_valid in the next cycle.
// Otherwise busy rises and the chain slides one cell per cycle, until the words sit
// against that end, before the transaction executes. Pushes give no result.
// Throughput: one transaction per cycle for runs on the same end, size and empty.
// Reset (rst_n low, synchronous): clear count, cell flags and state; the receiver cannot stall.
module double_ended_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  dq_pkg::dq_in_t in_item,
  output logic           out_valid,
  output dq_pkg::dq_out_t out_item
);
  import dq_pkg::*;

  // IDLE takes transactions; SLIDE moves the words toward the end that a
  // pending transaction needs, then executes it.
  typedef enum logic {
    ST_IDLE,
    ST_SLIDE
  } state_t;

  state_t            state_r, state_nxt;
  dq_op_t            op_r, op_nxt;
  logic [WORD_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  dq_out_t           out_item_r, out_item_nxt;

  dq_op_t            op_sel;
  logic [WORD_W-1:0] val_sel;
  logic              act;
  logic              is_front;
  logic              is_back;
  logic              q_empty;
  logic              q_full;
  logic              aligned;

  dq_ctl_t           ctl;
  dq_slot_t          front_s;
  dq_slot_t          back_s;
  logic [DEPTH-1:0]  vld;

  dq_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl),
    .front_o (front_s),
    .back_o  (back_s),
    .vld_o   (vld)
  );

  // In IDLE the live input drives the decision; in SLIDE the held one does.
  assign op_sel  = (state_r == ST_IDLE) ? dq_op_t'(in_item.operation) : op_r;
  assign val_sel = (state_r == ST_IDLE) ? in_item.push_value : val_r;
  assign act     = (state_r == ST_IDLE) ? start : 1'b1;

  assign is_front = (op_sel == OP_PUSH_FRONT) || (op_sel == OP_POP_FRONT) ||
                    (op_sel == OP_FRONT);
  assign is_back  = (op_sel == OP_PUSH_BACK) || (op_sel == OP_POP_BACK) ||
                    (op_sel == OP_BACK);
  assign q_empty  = (cnt_r == '0);
  assign q_full   = (cnt_r == CNT_W'(DEPTH));

  // Front work needs the words packed against cell 0, back work against the
  // last cell. An empty queue packs against both; so does a full one.
  assign aligned = q_empty || (is_front && vld[0]) || (is_back && vld[DEPTH-1]) ||
                   !(is_front || is_back);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ctl.cmd       = DQ_HOLD;
    ctl.left_in   = '{vld: 1'b0, data: val_sel};
    ctl.right_in  = '{vld: 1'b0, data: val_sel};

    if (act) begin
      if (!aligned) begin
        // Slide one cell toward the needed end; nothing drops off a valid cell.
        ctl.cmd   = is_front ? DQ_SHL : DQ_SHR;
        state_nxt = ST_SLIDE;
        op_nxt    = op_sel;
        val_nxt   = val_sel;
      end else begin
        state_nxt = ST_IDLE;
        unique case (op_sel) inside
          OP_PUSH_FRONT: begin
            // Drop the push when full.
            if (!q_full) begin
              ctl.cmd         = DQ_SHR;
              ctl.left_in.vld = 1'b1;
              cnt_nxt         = cnt_r + 1'b1;
            end
          end
          OP_PUSH_BACK: begin
            if (!q_full) begin
              ctl.cmd          = DQ_SHL;
              ctl.right_in.vld = 1'b1;
              cnt_nxt          = cnt_r + 1'b1;
            end
          end
          OP_SIZE: begin
            out_valid_nxt             = 1'b1;
            out_item_nxt.result_value = WORD_W'(cnt_r);
            out_item_nxt.was_empty    = 1'b0;
          end
          OP_EMPTY: begin
            out_valid_nxt             = 1'b1;
            out_item_nxt.result_value = WORD_W'(q_empty);
            out_item_nxt.was_empty    = 1'b0;
          end
          OP_POP_FRONT, OP_FRONT: begin
            out_valid_nxt = 1'b1;
            if (q_empty) begin
              out_item_nxt.result_value = '1;
              out_item_nxt.was_empty    = 1'b1;
            end else begin
              out_item_nxt.result_value = front_s.data;
              out_item_nxt.was_empty    = 1'b0;
              if (op_sel == OP_POP_FRONT) begin
                ctl.cmd = DQ_SHL;
                cnt_nxt = cnt_r - 1'b1;
              end
            end
          end
          OP_POP_BACK, OP_BACK: begin
            out_valid_nxt = 1'b1;
            if (q_empty) begin
              out_item_nxt.result_value = '1;
              out_item_nxt.was_empty    = 1'b1;
            end else begin
              out_item_nxt.result_value = back_s.data;
              out_item_nxt.was_empty    = 1'b0;
              if (op_sel == OP_POP_BACK) begin
                ctl.cmd = DQ_SHR;
                cnt_nxt = cnt_r - 1'b1;
              end
            end
          end
          default: begin
            out_valid_nxt = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    // Hold the pending transaction and the result payload; no reset needed.
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Occupied cells always match the count.
  a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld) == cnt_r)
    else $error("cell flags disagree with count");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("count above capacity");

  // A result comes from an accepted or pending transaction.
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start) || $past(busy)))
    else $error("result without transaction");

  // A transaction that had to slide ends busy when its result appears.
  a_slide_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(busy)) |-> !busy)
    else $error("still busy after slid transaction completed");

  a_empty_gives_minus_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.was_empty) |-> (out_item.result_value == -32'sd1))
    else $error("empty hit without -1");

endmodule

FILE: tb/double_ended_queue_tb.sv
`timescale 1ns / 1ps

module double_ended_queue_tb;
  import dq_pkg::*;

  // Shadow deque: mirrors the ring contents and queues the result each
  // transaction should produce.
  class deque_mirror_t;
    logic signed [31:0] ring [dq_pkg::DEPTH];
    int unsigned head_pos;
    int unsigned tail_pos;
    int unsigned word_count;
    dq_pkg::dq_out_t due_results [$];
    int unsigned mismatches;

    function new();
      head_pos   = 0;
      tail_pos   = 0;
      word_count = 0;
      mismatches = 0;
    endfunction

    function int unsigned step_back(int unsigned idx);
      return (idx == 0) ? dq_pkg::DEPTH - 1 : idx - 1;
    endfunction

    function int unsigned step_fwd(int unsigned idx);
      return (idx + 1 >= dq_pkg::DEPTH) ? 0 : idx + 1;
    endfunction

    function void take_op(dq_pkg::dq_in_t item);
      dq_op_t          op;
      dq_pkg::dq_out_t res;
      int unsigned     pos;
      bit              gives_result;
      op           = dq_op_t'(item.operation);
      res          = '0;
      gives_result = 1'b1;
      case (op) inside
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          gives_result = 1'b0;
          // drop the push when the ring is full
          if (word_count < dq_pkg::DEPTH) begin
            if (op == OP_PUSH_FRONT) begin
              head_pos       = step_back(head_pos);
              ring[head_pos] = item.push_value;
            end else begin
              ring[tail_pos] = item.push_value;
              tail_pos       = step_fwd(tail_pos);
            end
            word_count++;
          end
        end
        OP_SIZE:  res.result_value = word_count;
        OP_EMPTY: res.result_value = (word_count == 0) ? 1 : 0;
        default: begin
          if (word_count == 0) begin
            res.result_value = -1;
            res.was_empty    = 1'b1;
          end else begin
            pos = (op == OP_POP_FRONT || op == OP_FRONT) ? head_pos : step_back(tail_pos);
            res.result_value = ring[pos];
            if (op == OP_POP_FRONT) begin
              head_pos = step_fwd(head_pos);
              word_count--;
            end else if (op == OP_POP_BACK) begin
              tail_pos = pos;
              word_count--;
            end
          end
        end
      endcase
      if (gives_result)
        due_results.insert(due_results.size(), res);
    endfunction

    function void match_result(dq_pkg::dq_out_t got);
      dq_pkg::dq_out_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result expected none actual value %0d was_empty %0b", $time,
                 got.result_value, got.was_empty);
        mismatches++;
        return;
      end
      want = due_results[0];
      due_results.delete(0);
      if (got.result_value !== want.result_value) begin
        $display("%0t: result_value expected %0d actual %0d", $time,
                 want.result_value, got.result_value);
        mismatches++;
      end
      if (got.was_empty !== want.was_empty) begin
        $display("%0t: was_empty expected %0b actual %0b", $time,
                 want.was_empty, got.was_empty);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction
  endclass

  // The quiet limit leaves room for several slides across the whole chain.
  localparam int unsigned QUIET_LIMIT = 4 * dq_pkg::DEPTH + 100;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  dq_pkg::dq_in_t  in_item = '0;
  logic            out_valid;
  dq_pkg::dq_out_t out_item;

  deque_mirror_t book = new();
  int unsigned items_sent = 0;
  bit          idle_ok = 1'b1;

  double_ended_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Sample both channels at the edge. Check the result first so a stray
  // strobe can never be matched against the transaction taken at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        book.match_result(out_item);
      if (start && !busy)
        book.take_op(in_item);
    end
  end

  // Watchdog: count cycles in which neither channel moves anything.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid)
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mostly random words, with the signed extremes, zero and all-ones mixed in.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Present one transaction and hold it until the block takes it. Raise start
  // only once per step: when no idle follows, the next call simply reassigns it.
  task automatic send_op(dq_op_t op, logic [31:0] word);
    dq_pkg::dq_in_t item;
    item.operation  = op;
    item.push_value = word;
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    items_sent++;
    if (idle_ok && $urandom_range(0, 99) < 17) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Run of transactions against one end; switching ends makes the chain slide,
  // so keep runs together and only sprinkle in the occasional stray code.
  task automatic drive_run(bit at_back, int unsigned len, int unsigned push_pct,
                           int unsigned pop_pct);
    int unsigned roll;
    dq_op_t      op;
    for (int unsigned i = 0; i < len; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < push_pct)
        op = at_back ? OP_PUSH_BACK : OP_PUSH_FRONT;
      else if (roll < push_pct + pop_pct)
        op = at_back ? OP_POP_BACK : OP_POP_FRONT;
      else if (roll < 85)
        op = at_back ? OP_BACK : OP_FRONT;
      else if (roll < 95)
        op = $urandom_range(0, 1) ? OP_SIZE : OP_EMPTY;
      else
        op = dq_op_t'($urandom_range(0, 7));
      send_op(op, pick_word());
    end
  endtask

  initial begin : stimulus
    bit fill_back;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty queue: every pop and peek must answer -1 with the empty flag.
    send_op(OP_POP_FRONT, pick_word());
    send_op(OP_POP_BACK, pick_word());
    send_op(OP_FRONT, pick_word());
    send_op(OP_BACK, pick_word());
    send_op(OP_SIZE, pick_word());
    send_op(OP_EMPTY, pick_word());
    // Extremes at both ends.
    send_op(OP_PUSH_BACK, 32'h7fff_ffff);
    send_op(OP_PUSH_FRONT, 32'h8000_0000);
    send_op(OP_PUSH_BACK, 32'h0000_0000);
    send_op(OP_PUSH_FRONT, 32'hffff_ffff);
    send_op(OP_SIZE, 32'hffff_ffff);
    send_op(OP_EMPTY, 32'h8000_0000);
    send_op(OP_FRONT, 32'h7fff_ffff);
    send_op(OP_BACK, 32'h0000_0000);
    send_op(OP_POP_BACK, pick_word());
    send_op(OP_POP_FRONT, pick_word());
    send_op(OP_POP_FRONT, pick_word());
    send_op(OP_POP_BACK, pick_word());
    send_op(OP_POP_FRONT, pick_word());
    send_op(OP_EMPTY, pick_word());
    send_op(OP_SIZE, pick_word());

    // Mixed runs on a shallow queue.
    while (items_sent < 300)
      drive_run($urandom_range(0, 1), $urandom_range(1, 16), 40, 35);

    // Fill to the brim from one end with no idling, then push past full.
    idle_ok   = 1'b0;
    fill_back = $urandom_range(0, 1);
    for (int unsigned i = 0; i < dq_pkg::DEPTH + 64; i++) begin
      if ($urandom_range(0, 99) < 4)
        send_op($urandom_range(0, 1) ? OP_SIZE : (fill_back ? OP_BACK : OP_FRONT),
                pick_word());
      else
        send_op(fill_back ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_word());
    end

    // Probe the full ring: pushes must drop, pops reopen one slot.
    idle_ok = 1'b1;
    send_op(OP_PUSH_FRONT, pick_word());
    send_op(OP_PUSH_BACK, pick_word());
    send_op(OP_SIZE, pick_word());
    send_op(OP_EMPTY, pick_word());
    send_op(OP_FRONT, pick_word());
    send_op(OP_BACK, pick_word());
    send_op(OP_POP_FRONT, pick_word());
    send_op(OP_PUSH_BACK, pick_word());
    send_op(OP_PUSH_FRONT, pick_word());
    send_op(OP_POP_BACK, pick_word());
    send_op(OP_PUSH_FRONT, pick_word());
    send_op(OP_PUSH_FRONT, pick_word());
    send_op(OP_BACK, pick_word());

    // Drain-biased runs from both ends.
    while (items_sent < 1450)
      drive_run($urandom_range(0, 1), $urandom_range(1, 24), 25, 55);

    // Drop start and let the block settle; the watchdog bounds this wait.
    start <= 1'b0;
    while (book.pending() != 0 || busy)
      @(posedge clk);
    repeat (dq_pkg::DEPTH + 16) @(posedge clk);

    if (book.mismatches == 0 && book.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/dq_pkg.sv
hw/rtl/dq_cell.sv
hw/rtl/dq_chain.sv
hw/rtl/double_ended_queue.sv
tb/double_ended_queue_tb.sv
